/* hdl/tmcc_pkg.sv */
`default_nettype none

package tmcc_pkg;

	// field widths
	localparam int SAMPLE_W = 8;
	localparam int ADDR_W = 21;
	localparam int SLICE_W = 8;
	localparam int LEN_W = 9;
	localparam int GAIN_W = 16;
	localparam int NUM_CH = 3;
	localparam int NUM_W = GAIN_W + SLICE_W;

	// pixel store
	localparam int PIXEL_COUNT = 2097152;
	localparam int PIX_IDX_W = $clog2(PIXEL_COUNT);
	localparam int MAX_SLICES = 256;

	// gain divider: quotient bits retired per stage
	localparam int DIV_BITS_PER_STAGE = 4;
	localparam int DIV_STAGES = GAIN_W / DIV_BITS_PER_STAGE;

	// channel order
	localparam int CH_RED = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE = 2;

	// config port
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_RED = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_GREEN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_BLUE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_RED = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_GREEN = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_BLUE = 3'd6;

	typedef logic [NUM_CH-1:0][GAIN_W-1:0] rgb_gain_t;
	typedef logic [NUM_CH-1:0][SAMPLE_W-1:0] rgb_pix_t;

	localparam logic [LEN_W-1:0] LEN_RESET = 9'd16;
	localparam rgb_gain_t FIRST_RESET = {16'd56236, 16'd62299, 16'd64972};
	localparam rgb_gain_t LAST_RESET = {16'd34537, 16'd1953, 16'd3303};

	// one entry of the pixel store
	typedef struct packed {
		logic [SAMPLE_W-1:0] maxv;
		logic [SLICE_W-1:0]  mslice;
	} pix_t;

	// last-slice word leaving the accumulator
	typedef struct packed {
		logic [ADDR_W-1:0]   addr;
		logic [SAMPLE_W-1:0] maxv;
		logic [SLICE_W-1:0]  mslice;
	} hit_t;

	// divider word: partial remainder and dividend/quotient shift word per channel
	typedef struct packed {
		logic [ADDR_W-1:0]                addr;
		logic [SAMPLE_W-1:0]              maxv;
		logic [NUM_CH-1:0][SLICE_W-1:0]   rem;
		logic [NUM_CH-1:0][GAIN_W-1:0]    work;
	} div_t;

endpackage

`default_nettype wire

/* hdl/tmcc_accum.sv */
`default_nettype none

// pixel store with read-modify-write, one word per clock while a held last-slice word does not stall it
module tmcc_accum (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [tmcc_pkg::LEN_W-1:0]      len_eff,
	input  logic [tmcc_pkg::SLICE_W-1:0]    span,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [tmcc_pkg::SAMPLE_W-1:0]   sample_value,
	input  logic [tmcc_pkg::ADDR_W-1:0]     pixel_addr,
	input  logic [tmcc_pkg::SLICE_W-1:0]    slice_index,
	output logic                            out_valid,
	input  logic                            out_ready,
	output tmcc_pkg::hit_t                  out_word
);

	tmcc_pkg::pix_t mem [tmcc_pkg::PIXEL_COUNT];
	tmcc_pkg::pix_t rd_word_q;
	tmcc_pkg::pix_t fwd_word_q;
	tmcc_pkg::pix_t cur;
	tmcc_pkg::pix_t merged;
	logic fwd_q;

	logic                            vld_s1;
	logic                            last_s1;
	logic [tmcc_pkg::ADDR_W-1:0]     addr_s1;
	logic [tmcc_pkg::SAMPLE_W-1:0]   sample_s1;
	logic [tmcc_pkg::SLICE_W-1:0]    slice_s1;

	logic accept;
	logic drop;
	logic s1_go;
	logic fwd_hit;
	logic [tmcc_pkg::PIX_IDX_W-1:0] rd_idx;
	logic [tmcc_pkg::PIX_IDX_W-1:0] wr_idx;

	assign drop = tmcc_pkg::LEN_W'(slice_index) >= len_eff;
	assign s1_go = vld_s1 && (!last_s1 || out_ready);
	assign in_ready = !vld_s1 || s1_go;
	assign accept = in_valid && in_ready;

	assign rd_idx = pixel_addr[tmcc_pkg::PIX_IDX_W-1:0];
	assign wr_idx = addr_s1[tmcc_pkg::PIX_IDX_W-1:0];
	// write at this edge is not yet visible to a read at the same edge
	assign fwd_hit = s1_go && (rd_idx == wr_idx);

	assign cur = fwd_q ? fwd_word_q : rd_word_q;

	always_comb begin
		if (slice_s1 == '0 || sample_s1 > cur.maxv) begin
			merged.maxv = sample_s1;
			merged.mslice = slice_s1;
		end else begin
			merged = cur;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			mem[wr_idx] <= merged;
		end
		if (accept) begin
			rd_word_q <= mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			fwd_q <= 1'b0;
		end else begin
			if (in_ready) begin
				vld_s1 <= in_valid && !drop;
			end
			if (accept) begin
				fwd_q <= fwd_hit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1 <= pixel_addr;
			sample_s1 <= sample_value;
			slice_s1 <= slice_index;
			last_s1 <= slice_index == span;
			fwd_word_q <= merged;
		end
	end

	assign out_valid = vld_s1 && last_s1;
	assign out_word.addr = addr_s1;
	assign out_word.maxv = merged.maxv;
	assign out_word.mslice = (merged.mslice > span) ? span : merged.mslice;

endmodule

`default_nettype wire

/* hdl/tmcc_gain_num.sv */
`default_nettype none

// interpolation numerator F*(span-s) + E*s per channel
module tmcc_gain_num (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [tmcc_pkg::SLICE_W-1:0]  span,
	input  tmcc_pkg::rgb_gain_t           color_first,
	input  tmcc_pkg::rgb_gain_t           color_last,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  tmcc_pkg::hit_t                in_word,
	output logic                          out_valid,
	input  logic                          out_ready,
	output tmcc_pkg::div_t                out_word
);

	logic            vld_s2;
	tmcc_pkg::div_t  word_s2;
	tmcc_pkg::div_t  nxt;

	always_comb begin
		logic [tmcc_pkg::SLICE_W-1:0] rest;
		logic [tmcc_pkg::NUM_W-1:0]   num;
		nxt.addr = in_word.addr;
		nxt.maxv = in_word.maxv;
		rest = span - in_word.mslice;
		for (int c = 0; c < tmcc_pkg::NUM_CH; c++) begin
			num = tmcc_pkg::NUM_W'(color_first[c]) * tmcc_pkg::NUM_W'(rest)
				+ tmcc_pkg::NUM_W'(color_last[c]) * tmcc_pkg::NUM_W'(in_word.mslice);
			// upper part is already below span
			nxt.rem[c] = num[tmcc_pkg::NUM_W-1:tmcc_pkg::GAIN_W];
			nxt.work[c] = num[tmcc_pkg::GAIN_W-1:0];
		end
	end

	assign in_ready = !vld_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (in_ready) begin
			vld_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s2 <= nxt;
		end
	end

	assign out_valid = vld_s2;
	assign out_word = word_s2;

endmodule

`default_nettype wire

/* hdl/tmcc_div_stage.sv */
`default_nettype none

// one stage of the restoring divider by span, four quotient bits per stage
module tmcc_div_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [tmcc_pkg::SLICE_W-1:0]  span,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  tmcc_pkg::div_t                in_word,
	output logic                          out_valid,
	input  logic                          out_ready,
	output tmcc_pkg::div_t                out_word
);

	logic            vld_s1;
	tmcc_pkg::div_t  word_s1;
	tmcc_pkg::div_t  nxt;

	// shift in one dividend bit, retire one quotient bit at the bottom
	function automatic logic [tmcc_pkg::SLICE_W+tmcc_pkg::GAIN_W-1:0] div_step(
		input logic [tmcc_pkg::SLICE_W-1:0] rem,
		input logic [tmcc_pkg::GAIN_W-1:0]  work,
		input logic [tmcc_pkg::SLICE_W-1:0] dvs
	);
		logic [tmcc_pkg::SLICE_W:0] trial;
		logic                       qbit;
		trial = {rem, work[tmcc_pkg::GAIN_W-1]};
		qbit = trial >= {1'b0, dvs};
		if (qbit) begin
			trial = trial - {1'b0, dvs};
		end
		return {trial[tmcc_pkg::SLICE_W-1:0], work[tmcc_pkg::GAIN_W-2:0], qbit};
	endfunction

	always_comb begin
		nxt = in_word;
		for (int k = 0; k < tmcc_pkg::DIV_BITS_PER_STAGE; k++) begin
			for (int c = 0; c < tmcc_pkg::NUM_CH; c++) begin
				{nxt.rem[c], nxt.work[c]} = div_step(nxt.rem[c], nxt.work[c], span);
			end
		end
	end

	assign in_ready = !vld_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= nxt;
		end
	end

	assign out_valid = vld_s1;
	assign out_word = word_s1;

endmodule

`default_nettype wire

/* hdl/tmcc_shade.sv */
`default_nettype none

// max times gain, top byte, into the output register
module tmcc_shade (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  tmcc_pkg::div_t                 in_word,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [tmcc_pkg::ADDR_W-1:0]    out_addr,
	output tmcc_pkg::rgb_pix_t             out_rgb
);

	localparam int PROD_W = tmcc_pkg::SAMPLE_W + tmcc_pkg::GAIN_W;

	logic                              vld_s7;
	logic [tmcc_pkg::ADDR_W-1:0]       addr_s7;
	tmcc_pkg::rgb_pix_t                rgb_s7;
	tmcc_pkg::rgb_pix_t                rgb_nxt;

	always_comb begin
		logic [PROD_W-1:0] prod;
		for (int c = 0; c < tmcc_pkg::NUM_CH; c++) begin
			prod = PROD_W'(in_word.maxv) * PROD_W'(in_word.work[c]);
			rgb_nxt[c] = prod[PROD_W-1:tmcc_pkg::GAIN_W];
		end
	end

	assign in_ready = !vld_s7 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (in_ready) begin
			vld_s7 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			addr_s7 <= in_word.addr;
			rgb_s7 <= rgb_nxt;
		end
	end

	assign out_valid = vld_s7;
	assign out_addr = addr_s7;
	assign out_rgb = rgb_s7;

endmodule

`default_nettype wire

/* hdl/temporal_max_color_coder_core.sv */
// Temporal color-coded maximum projection. Each input word is one 8-bit sample of one pixel
// in one slice; the core keeps, per pixel, the running maximum and the first slice that
// reached it (slice 0 starts the pixel over, later slices win only when strictly greater).
// Words with a slice at or beyond the window length (register REG_LENGTH, clamped to
// 2..MAX_SLICES) are swallowed. The word carrying the last slice of the window (window
// length minus one) yields one RGB word: the maximum times a Q0.16 gain interpolated from
// the first-slice color to the last-slice color, truncated.
// One word is taken every clock unless back-pressure reaches the store; the rate is set by the
// read-modify-write on the pixel store (one read and one write a clock), which a one-deep
// bypass keeps at one word per clock even for the same pixel twice in a row. Each result
// passes seven register stages (store read, numerator, four divider stages, color multiply),
// the first of which loads on the accepting edge. The pipeline has no feedback beyond the
// bypass, so back-pressure only stalls stages that are full. The store is never cleared:
// a pixel must see slice 0 before it is read. Write configuration only while the core is idle.
`default_nettype none

module temporal_max_color_coder_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_we,
	input  logic [tmcc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tmcc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	// sample words
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [tmcc_pkg::SAMPLE_W-1:0]   sample_value,
	input  logic [tmcc_pkg::ADDR_W-1:0]     pixel_addr,
	input  logic [tmcc_pkg::SLICE_W-1:0]    slice_index,
	// colored pixel words
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [tmcc_pkg::ADDR_W-1:0]     out_pixel_addr,
	output logic [tmcc_pkg::SAMPLE_W-1:0]   red,
	output logic [tmcc_pkg::SAMPLE_W-1:0]   green,
	output logic [tmcc_pkg::SAMPLE_W-1:0]   blue
);

	// config registers
	logic [tmcc_pkg::LEN_W-1:0]  len_q;
	tmcc_pkg::rgb_gain_t         first_q;
	tmcc_pkg::rgb_gain_t         last_q;

	// effective window length and span (length minus one)
	logic [tmcc_pkg::LEN_W-1:0]   len_eff;
	logic [tmcc_pkg::LEN_W-1:0]   len_m1;
	logic [tmcc_pkg::SLICE_W-1:0] span;

	// inter-stage channels
	logic            hit_valid;
	logic            hit_ready;
	tmcc_pkg::hit_t  hit_word;

	logic [tmcc_pkg::DIV_STAGES:0] div_valid;
	logic [tmcc_pkg::DIV_STAGES:0] div_ready;
	tmcc_pkg::div_t                div_word [tmcc_pkg::DIV_STAGES+1];

	tmcc_pkg::rgb_pix_t rgb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= tmcc_pkg::LEN_RESET;
			first_q <= tmcc_pkg::FIRST_RESET;
			last_q <= tmcc_pkg::LAST_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tmcc_pkg::REG_LENGTH: begin
					len_q <= cfg_wdata[tmcc_pkg::LEN_W-1:0];
				end
				tmcc_pkg::REG_FIRST_RED: begin
					first_q[tmcc_pkg::CH_RED] <= cfg_wdata[tmcc_pkg::GAIN_W-1:0];
				end
				tmcc_pkg::REG_FIRST_GREEN: begin
					first_q[tmcc_pkg::CH_GREEN] <= cfg_wdata[tmcc_pkg::GAIN_W-1:0];
				end
				tmcc_pkg::REG_FIRST_BLUE: begin
					first_q[tmcc_pkg::CH_BLUE] <= cfg_wdata[tmcc_pkg::GAIN_W-1:0];
				end
				tmcc_pkg::REG_LAST_RED: begin
					last_q[tmcc_pkg::CH_RED] <= cfg_wdata[tmcc_pkg::GAIN_W-1:0];
				end
				tmcc_pkg::REG_LAST_GREEN: begin
					last_q[tmcc_pkg::CH_GREEN] <= cfg_wdata[tmcc_pkg::GAIN_W-1:0];
				end
				tmcc_pkg::REG_LAST_BLUE: begin
					last_q[tmcc_pkg::CH_BLUE] <= cfg_wdata[tmcc_pkg::GAIN_W-1:0];
				end
				default: begin
					// unused index: ignored
				end
			endcase
		end
	end

	// length clamps to 2..MAX_SLICES
	always_comb begin
		priority if (len_q < tmcc_pkg::LEN_W'(2)) begin
			len_eff = tmcc_pkg::LEN_W'(2);
		end else if (len_q > tmcc_pkg::LEN_W'(tmcc_pkg::MAX_SLICES)) begin
			len_eff = tmcc_pkg::LEN_W'(tmcc_pkg::MAX_SLICES);
		end else begin
			len_eff = len_q;
		end
	end

	assign len_m1 = len_eff - tmcc_pkg::LEN_W'(1);
	assign span = len_m1[tmcc_pkg::SLICE_W-1:0];

	// stage 1: store read, max/slice update, write back
	tmcc_accum u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.len_eff      (len_eff),
		.span         (span),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample_value (sample_value),
		.pixel_addr   (pixel_addr),
		.slice_index  (slice_index),
		.out_valid    (hit_valid),
		.out_ready    (hit_ready),
		.out_word     (hit_word)
	);

	// stage 2: interpolation numerator
	tmcc_gain_num u_gain_num (
		.clk         (clk),
		.arst_n      (arst_n),
		.span        (span),
		.color_first (first_q),
		.color_last  (last_q),
		.in_valid    (hit_valid),
		.in_ready    (hit_ready),
		.in_word     (hit_word),
		.out_valid   (div_valid[0]),
		.out_ready   (div_ready[0]),
		.out_word    (div_word[0])
	);

	// stages 3..6: divide by span
	for (genvar g = 0; g < tmcc_pkg::DIV_STAGES; g++) begin : g_div
		tmcc_div_stage u_div_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.span      (span),
			.in_valid  (div_valid[g]),
			.in_ready  (div_ready[g]),
			.in_word   (div_word[g]),
			.out_valid (div_valid[g+1]),
			.out_ready (div_ready[g+1]),
			.out_word  (div_word[g+1])
		);
	end

	// stage 7: color multiply, output register
	tmcc_shade u_shade (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid[tmcc_pkg::DIV_STAGES]),
		.in_ready  (div_ready[tmcc_pkg::DIV_STAGES]),
		.in_word   (div_word[tmcc_pkg::DIV_STAGES]),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_addr  (out_pixel_addr),
		.out_rgb   (rgb)
	);

	assign red = rgb[tmcc_pkg::CH_RED];
	assign green = rgb[tmcc_pkg::CH_GREEN];
	assign blue = rgb[tmcc_pkg::CH_BLUE];

	// a free output lets every stage move, so the input must be open
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("in_ready low while out_ready high");

	// divider remainder stays below the divisor
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		div_valid[tmcc_pkg::DIV_STAGES] |->
			(div_word[tmcc_pkg::DIV_STAGES].rem[tmcc_pkg::CH_RED] < span) &&
			(div_word[tmcc_pkg::DIV_STAGES].rem[tmcc_pkg::CH_GREEN] < span) &&
			(div_word[tmcc_pkg::DIV_STAGES].rem[tmcc_pkg::CH_BLUE] < span))
		else $error("divider remainder not below span");

	// interpolated gain never exceeds both end colors
	a_gain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		div_valid[tmcc_pkg::DIV_STAGES] |->
			((div_word[tmcc_pkg::DIV_STAGES].work[tmcc_pkg::CH_RED] <=
				first_q[tmcc_pkg::CH_RED]) ||
			 (div_word[tmcc_pkg::DIV_STAGES].work[tmcc_pkg::CH_RED] <=
				last_q[tmcc_pkg::CH_RED])) &&
			((div_word[tmcc_pkg::DIV_STAGES].work[tmcc_pkg::CH_GREEN] <=
				first_q[tmcc_pkg::CH_GREEN]) ||
			 (div_word[tmcc_pkg::DIV_STAGES].work[tmcc_pkg::CH_GREEN] <=
				last_q[tmcc_pkg::CH_GREEN])) &&
			((div_word[tmcc_pkg::DIV_STAGES].work[tmcc_pkg::CH_BLUE] <=
				first_q[tmcc_pkg::CH_BLUE]) ||
			 (div_word[tmcc_pkg::DIV_STAGES].work[tmcc_pkg::CH_BLUE] <=
				last_q[tmcc_pkg::CH_BLUE])))
		else $error("interpolated gain outside color range");

endmodule

`default_nettype wire

/* tb/sv/temporal_max_color_coder_core_tb.sv */
`timescale 1ns / 1ps

module temporal_max_color_coder_core_tb;

	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 8;
	localparam int SETTLE_CYCLES = 20;      // settling margin past the core pipeline
	localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
	localparam int CYCLE_LIMIT   = 300000;
	localparam int NUM_PHASES    = 10;
	localparam int PHASE_WORDS   = 125;

	// index past the register list: a write there must change nothing
	localparam logic [tmcc_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;

	// one colored pixel as it leaves the core
	typedef struct {
		logic [tmcc_pkg::ADDR_W-1:0] addr;
		tmcc_pkg::rgb_pix_t          color;
	} color_word_t;

	// directed stimulus rows
	typedef enum logic [1:0] {ROW_WORD, ROW_WORD_CHK, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t                       kind;
		logic [tmcc_pkg::SAMPLE_W-1:0]   sample;
		logic [tmcc_pkg::ADDR_W-1:0]     addr;
		logic [tmcc_pkg::SLICE_W-1:0]    slice;
		logic [tmcc_pkg::CFG_IDX_W-1:0]  reg_idx;
		logic [tmcc_pkg::CFG_DATA_W-1:0] reg_val;
		tmcc_pkg::rgb_pix_t              color;   // typed-in result, ROW_WORD_CHK only
	} dir_row_t;

	// pixel windows in flight during the random part
	typedef struct {
		logic [tmcc_pkg::ADDR_W-1:0] addr;
		int                          mids;        // in-between slices still to send
	} window_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_we = 1'b0;
	logic [tmcc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [tmcc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	logic [tmcc_pkg::SAMPLE_W-1:0]   sample_value = '0;
	logic [tmcc_pkg::ADDR_W-1:0]     pixel_addr = '0;
	logic [tmcc_pkg::SLICE_W-1:0]    slice_index = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic [tmcc_pkg::ADDR_W-1:0]     out_pixel_addr;
	logic [tmcc_pkg::SAMPLE_W-1:0]   red;
	logic [tmcc_pkg::SAMPLE_W-1:0]   green;
	logic [tmcc_pkg::SAMPLE_W-1:0]   blue;

	temporal_max_color_coder_core u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.sample_value   (sample_value),
		.pixel_addr     (pixel_addr),
		.slice_index    (slice_index),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_pixel_addr (out_pixel_addr),
		.red            (red),
		.green          (green),
		.blue           (blue)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Shadow of the core: registers plus per-pixel max / winning slice
	// ------------------------------------------------------------------
	logic [tmcc_pkg::LEN_W-1:0]    len_shadow = tmcc_pkg::LEN_RESET;
	tmcc_pkg::rgb_gain_t           first_gain = tmcc_pkg::FIRST_RESET;
	tmcc_pkg::rgb_gain_t           last_gain = tmcc_pkg::LAST_RESET;
	logic [tmcc_pkg::SAMPLE_W-1:0] peak_mem [int unsigned];
	logic [tmcc_pkg::SLICE_W-1:0]  peak_slice [int unsigned];
	logic [tmcc_pkg::ADDR_W-1:0]   written_q [$];     // pixels that are safe to read back

	color_word_t         pending_colors [$];
	dir_row_t            dir_rows [$];

	int                  err_cnt = 0;
	int                  words_taken = 0;
	int                  pixels_seen = 0;
	int                  settings_done = 0;
	int                  cycle_cnt = 0;

	// pacing: 27/57 -> 57/27 -> none, switched on word count
	int unsigned         send_idle_pct = 27;
	int unsigned         recv_idle_pct = 57;

	// receiver hold-off request / bookkeeping
	int                  hold_asked = 0;
	int                  hold_seen = 0;
	int                  hold_left = 0;

	// slices per window as the core sees it: clamped to [2, MAX_SLICES]
	function automatic int unsigned window_len();
		int unsigned raw;
		raw = 32'(len_shadow);
		if (raw < 2) return 2;
		if (raw > tmcc_pkg::MAX_SLICES) return tmcc_pkg::MAX_SLICES;
		return raw;
	endfunction

	// one channel: max times gain interpolated from first to last color, >> 16
	function automatic logic [tmcc_pkg::SAMPLE_W-1:0] tint(
		input logic [tmcc_pkg::SAMPLE_W-1:0] peak,
		input logic [tmcc_pkg::SLICE_W-1:0] at_slice, input int unsigned wlen,
		input logic [tmcc_pkg::GAIN_W-1:0] g_first, input logic [tmcc_pkg::GAIN_W-1:0] g_last);
		logic [31:0] span;
		logic [31:0] num;
		logic [31:0] gain;
		logic [31:0] prod;
		span = wlen - 1;
		num  = 32'(g_first) * (span - 32'(at_slice)) + 32'(g_last) * 32'(at_slice);
		gain = num / span;
		prod = 32'(peak) * gain;
		return prod[23:16];
	endfunction

	// fold one accepted sample into the shadow store; last slice yields a pixel
	function automatic void fold_sample(input logic [tmcc_pkg::SAMPLE_W-1:0] s,
		input logic [tmcc_pkg::ADDR_W-1:0] a, input logic [tmcc_pkg::SLICE_W-1:0] sl,
		output bit hit, output color_word_t w);
		int unsigned wlen;
		int unsigned slot;
		int unsigned slv;
		logic [tmcc_pkg::SLICE_W-1:0] at_slice;
		wlen = window_len();
		slot = 32'(a) % tmcc_pkg::PIXEL_COUNT;
		slv  = 32'(sl);
		hit  = 1'b0;
		w.addr  = a;
		w.color = '0;
		if (slv >= wlen)
			return;                     // outside the window: swallowed
		if (!peak_mem.exists(slot)) begin
			written_q.push_back(a);
			peak_mem[slot]   = s;
			peak_slice[slot] = sl;
		end else if (slv == 0 || s > peak_mem[slot]) begin
			peak_mem[slot]   = s;
			peak_slice[slot] = sl;
		end
		if (slv != wlen - 1)
			return;
		// a winner left by a longer window is pinned to the last slice
		at_slice = (32'(peak_slice[slot]) > wlen - 1) ?
			tmcc_pkg::SLICE_W'(wlen - 1) : peak_slice[slot];
		for (int ch = 0; ch < tmcc_pkg::NUM_CH; ch++)
			w.color[ch] = tint(peak_mem[slot], at_slice, wlen, first_gain[ch], last_gain[ch]);
		hit = 1'b1;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_cnt++;
		end
	endfunction

	function automatic tmcc_pkg::rgb_gain_t rand_gain();
		tmcc_pkg::rgb_gain_t g;
		for (int ch = 0; ch < tmcc_pkg::NUM_CH; ch++)
			g[ch] = tmcc_pkg::GAIN_W'($urandom_range(0, 65535));
		return g;
	endfunction

	function automatic void add_word(input logic [tmcc_pkg::SAMPLE_W-1:0] s,
		input logic [tmcc_pkg::ADDR_W-1:0] a, input logic [tmcc_pkg::SLICE_W-1:0] sl);
		dir_row_t r;
		r = '{kind: ROW_WORD, sample: s, addr: a, slice: sl, reg_idx: '0, reg_val: '0,
			color: '0};
		dir_rows.push_back(r);
	endfunction

	function automatic void add_chk(input logic [tmcc_pkg::SAMPLE_W-1:0] s,
		input logic [tmcc_pkg::ADDR_W-1:0] a, input logic [tmcc_pkg::SLICE_W-1:0] sl,
		input logic [tmcc_pkg::SAMPLE_W-1:0] r_v, input logic [tmcc_pkg::SAMPLE_W-1:0] g_v,
		input logic [tmcc_pkg::SAMPLE_W-1:0] b_v);
		dir_row_t r;
		r = '{kind: ROW_WORD_CHK, sample: s, addr: a, slice: sl, reg_idx: '0, reg_val: '0,
			color: '0};
		r.color[tmcc_pkg::CH_RED]   = r_v;
		r.color[tmcc_pkg::CH_GREEN] = g_v;
		r.color[tmcc_pkg::CH_BLUE]  = b_v;
		dir_rows.push_back(r);
	endfunction

	function automatic void add_cfg(input logic [tmcc_pkg::CFG_IDX_W-1:0] idx,
		input logic [tmcc_pkg::CFG_DATA_W-1:0] val);
		dir_row_t r;
		r = '{kind: ROW_CFG, sample: '0, addr: '0, slice: '0, reg_idx: idx, reg_val: val,
			color: '0};
		dir_rows.push_back(r);
	endfunction

	// ------------------------------------------------------------------
	// Driving
	// ------------------------------------------------------------------

	// offer one sample word and hold it until taken; the expectation is
	// queued at the accepting edge (a result cannot come out that early)
	task automatic push_sample(input logic [tmcc_pkg::SAMPLE_W-1:0] s,
		input logic [tmcc_pkg::ADDR_W-1:0] a, input logic [tmcc_pkg::SLICE_W-1:0] sl,
		input bit typed, input tmcc_pkg::rgb_pix_t typed_color);
		bit          hit;
		color_word_t w;
		in_valid     <= 1'b1;
		sample_value <= s;
		pixel_addr   <= a;
		slice_index  <= sl;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		fold_sample(s, a, sl, hit, w);
		if (typed) begin
			hit     = 1'b1;
			w.color = typed_color;
		end
		if (hit)
			pending_colors.push_back(w);
		words_taken++;
		if (words_taken < 420) begin
			send_idle_pct = 27;
			recv_idle_pct = 57;
		end else if (words_taken < 840) begin
			send_idle_pct = 57;
			recv_idle_pct = 27;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
	endtask

	// random sender gaps; the first lowering lands on the accepting edge
	task automatic pace_sender();
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// stop offering and let every outstanding pixel come out, then settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_colors.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [tmcc_pkg::CFG_IDX_W-1:0] idx,
		input logic [tmcc_pkg::CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			tmcc_pkg::REG_LENGTH:      len_shadow = val[tmcc_pkg::LEN_W-1:0];
			tmcc_pkg::REG_FIRST_RED:   first_gain[tmcc_pkg::CH_RED] = val;
			tmcc_pkg::REG_FIRST_GREEN: first_gain[tmcc_pkg::CH_GREEN] = val;
			tmcc_pkg::REG_FIRST_BLUE:  first_gain[tmcc_pkg::CH_BLUE] = val;
			tmcc_pkg::REG_LAST_RED:    last_gain[tmcc_pkg::CH_RED] = val;
			tmcc_pkg::REG_LAST_GREEN:  last_gain[tmcc_pkg::CH_GREEN] = val;
			tmcc_pkg::REG_LAST_BLUE:   last_gain[tmcc_pkg::CH_BLUE] = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic apply_setting(input logic [tmcc_pkg::CFG_DATA_W-1:0] len_val,
		input tmcc_pkg::rgb_gain_t fg, input tmcc_pkg::rgb_gain_t lg);
		cfg_write(tmcc_pkg::REG_LENGTH, len_val);
		cfg_write(tmcc_pkg::REG_FIRST_RED, fg[tmcc_pkg::CH_RED]);
		cfg_write(tmcc_pkg::REG_FIRST_GREEN, fg[tmcc_pkg::CH_GREEN]);
		cfg_write(tmcc_pkg::REG_FIRST_BLUE, fg[tmcc_pkg::CH_BLUE]);
		cfg_write(tmcc_pkg::REG_LAST_RED, lg[tmcc_pkg::CH_RED]);
		cfg_write(tmcc_pkg::REG_LAST_GREEN, lg[tmcc_pkg::CH_GREEN]);
		cfg_write(tmcc_pkg::REG_LAST_BLUE, lg[tmcc_pkg::CH_BLUE]);
		settings_done++;
	endtask

	// Random traffic for one setting. Mostly proper windows: slice 0, a few
	// in-between slices, then the last slice, interleaved over `ways` pixels.
	// Some noise: out-of-window slices and stray slices into pixels that hold
	// data from an earlier window (no slice 0 first). Never-written pixels
	// only ever get slice 0.
	task automatic run_phase(input int words, input int ways);
		window_t                       wins [$];
		window_t                       nw;
		int unsigned                   wlen;
		int                            pick;
		logic [tmcc_pkg::ADDR_W-1:0]   a;
		logic [tmcc_pkg::SLICE_W-1:0]  sl;
		logic [tmcc_pkg::SAMPLE_W-1:0] s;
		logic [31:0]                   rnd;
		wlen = window_len();
		for (int n = 0; n < words; n++) begin
			if ($urandom_range(99) < 12 && written_q.size() != 0) begin
				a = written_q[$urandom_range(0, written_q.size() - 1)];
				if (wlen < tmcc_pkg::MAX_SLICES && $urandom_range(1) == 0)
					sl = tmcc_pkg::SLICE_W'($urandom_range(wlen, 255));      // swallowed
				else
					sl = tmcc_pkg::SLICE_W'($urandom_range(1, wlen - 1));
			end else if (wins.size() < ways && (wins.size() == 0 || $urandom_range(2) == 0)) begin
				if (written_q.size() != 0 && $urandom_range(3) == 0) begin
					a = written_q[$urandom_range(0, written_q.size() - 1)];
				end else begin
					rnd = $urandom();
					a   = rnd[tmcc_pkg::ADDR_W-1:0];
				end
				sl      = '0;
				nw.addr = a;
				nw.mids = (wlen > 2) ? int'($urandom_range(0, 4)) : 0;
				wins.push_back(nw);
			end else begin
				pick = int'($urandom_range(0, wins.size() - 1));
				a    = wins[pick].addr;
				if (wins[pick].mids > 0) begin
					sl = tmcc_pkg::SLICE_W'($urandom_range(1, wlen - 2));
					wins[pick].mids--;
				end else begin
					sl = tmcc_pkg::SLICE_W'(wlen - 1);
					wins.delete(pick);
				end
			end
			case ($urandom_range(9))
				0:       s = '0;
				1:       s = '1;
				default: s = tmcc_pkg::SAMPLE_W'($urandom_range(0, 255));
			endcase
			push_sample(s, a, sl, 1'b0, '0);
			pace_sender();
		end
	endtask

	// ------------------------------------------------------------------
	// Receiver: random ready, plus a long hold-off counted here on request
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_asked) begin
			hold_seen <= hold_asked;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// ------------------------------------------------------------------
	// Result check: every taken pixel word against the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		color_word_t w;
		if (arst_n && out_valid && out_ready) begin
			if (pending_colors.size() == 0) begin
				$error("unexpected colored pixel word, addr %0h", out_pixel_addr);
				err_cnt++;
			end else begin
				w = pending_colors.pop_front();
				check_field("out_pixel_addr", 32'(w.addr), 32'(out_pixel_addr));
				check_field("red", 32'(w.color[tmcc_pkg::CH_RED]), 32'(red));
				check_field("green", 32'(w.color[tmcc_pkg::CH_GREEN]), 32'(green));
				check_field("blue", 32'(w.color[tmcc_pkg::CH_BLUE]), 32'(blue));
				pixels_seen++;
			end
		end
	end

	// watchdog
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("timeout after %0d cycles, %0d pixels outstanding", cycle_cnt,
			pending_colors.size());
		$display("RESULT: ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		logic [tmcc_pkg::CFG_DATA_W-1:0] len_val;
		tmcc_pkg::rgb_gain_t             fg;
		tmcc_pkg::rgb_gain_t             lg;
		int                              ways;

		// Directed rows. Reset setting first: window of 16, so slice 15 closes.
		// Slice 0 at full scale then a dim last slice -> first color exactly.
		add_word(8'd255, 21'h155555, 8'd0);
		add_chk(8'd0, 21'h155555, 8'd15, 8'd252, 8'd242, 8'd218);
		// slices past the window are swallowed, store untouched
		add_word(8'd255, 21'h155555, 8'd16);
		add_word(8'd255, 21'h155555, 8'd255);
		add_chk(8'd0, 21'h155555, 8'd15, 8'd252, 8'd242, 8'd218);
		// max reached on the last slice -> last color exactly
		add_word(8'd0, 21'h1FFFFF, 8'd0);
		add_chk(8'd255, 21'h1FFFFF, 8'd15, 8'd12, 8'd7, 8'd134);
		// a tie does not move the winning slice
		add_word(8'd100, 21'h000000, 8'd0);
		add_word(8'd200, 21'h000000, 8'd7);
		add_word(8'd200, 21'h000000, 8'd9);
		add_word(8'd150, 21'h000000, 8'd15);
		// same pixel back to back through the store bypass
		add_word(8'd10, 21'h0AAAAA, 8'd0);
		add_word(8'd20, 21'h0AAAAA, 8'd1);
		add_word(8'd30, 21'h0AAAAA, 8'd2);
		add_word(8'd5, 21'h0AAAAA, 8'd15);
		// all-zero pixel
		add_word(8'd0, 21'h000001, 8'd0);
		add_chk(8'd0, 21'h000001, 8'd15, 8'd0, 8'd0, 8'd0);
		// length 0 acts as 2
		add_cfg(tmcc_pkg::REG_LENGTH, 16'd0);
		add_word(8'd255, 21'h100000, 8'd0);
		add_chk(8'd0, 21'h100000, 8'd1, 8'd252, 8'd242, 8'd218);
		add_word(8'd77, 21'h100000, 8'd2);
		// length 1 acts as 2; a write past the register list is ignored
		add_cfg(tmcc_pkg::REG_LENGTH, 16'd1);
		add_cfg(REG_NONE, 16'd3);
		add_word(8'd1, 21'h0FFFFF, 8'd0);
		add_chk(8'd255, 21'h0FFFFF, 8'd1, 8'd12, 8'd7, 8'd134);
		// no slice 0 this window: stale winner at slice 15 pinned to slice 1
		add_chk(8'd0, 21'h1FFFFF, 8'd1, 8'd12, 8'd7, 8'd134);
		// slice 0 restarts a pixel even with a smaller sample
		add_word(8'd3, 21'h155555, 8'd0);
		add_chk(8'd0, 21'h155555, 8'd1, 8'd2, 8'd2, 8'd2);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				wait_idle();
				cfg_write(dir_rows[i].reg_idx, dir_rows[i].reg_val);
			end else begin
				push_sample(dir_rows[i].sample, dir_rows[i].addr, dir_rows[i].slice,
					dir_rows[i].kind == ROW_WORD_CHK, dir_rows[i].color);
				pace_sender();
			end
		end

		// Random part: one setting per phase, core drained between phases.
		for (int p = 0; p < NUM_PHASES; p++) begin
			fg   = rand_gain();
			lg   = rand_gain();
			ways = int'($urandom_range(1, 6));
			case (p)
				0: begin
					len_val = 16'hFE04;     // upper data bits set, length 4
					ways    = 3;
				end
				1: begin
					len_val = 16'd2;
					fg      = '0;
					lg      = '1;
					ways    = 4;
				end
				2: begin
					len_val = 16'd3;
					fg      = '1;
					lg      = '0;
					ways    = 2;
				end
				3: len_val = 16'd257;         // clamps to the max window
				4: begin
					len_val = 16'd9;
					ways    = 1;            // one open window at a time: back-to-back words to its pixel hit the bypass
				end
				5: len_val = 16'd511;
				6: len_val = 16'd256;
				default: len_val = tmcc_pkg::CFG_DATA_W'($urandom_range(2, 24));
			endcase
			wait_idle();
			apply_setting(len_val, fg, lg);
			// short windows and a long hold-off: the core fills and stalls input
			if (p == 1)
				hold_asked++;
			run_phase(PHASE_WORDS, ways);
		end

		wait_idle();
		$display("%0d sample words, %0d colored pixels checked, %0d register settings",
			words_taken, pixels_seen, settings_done);
		$display("windows from 2 to %0d slices, gains at both extremes, %0d mismatches",
			tmcc_pkg::MAX_SLICES, err_cnt);
		if (err_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* temporal_max_color_coder_core.f */
hdl/tmcc_pkg.sv
hdl/tmcc_accum.sv
hdl/tmcc_gain_num.sv
hdl/tmcc_div_stage.sv
hdl/tmcc_shade.sv
hdl/temporal_max_color_coder_core.sv
tb/sv/temporal_max_color_coder_core_tb.sv
